// ===== rtl/core/hvirq_pkg.sv =====
// package for the raster-position interrupt unit
// request kinds, register indexes, raster constants and shared structs; no dependencies
package hvirq_pkg;

   // width of a flat raster position in clocks, wide enough for a wrapped target
   localparam int POS_W        = 21;
   localparam int FRAME_W      = 20;
   localparam int LINE_CLOCKS  = 1364;
   localparam int NTSC_LINES   = 262;
   localparam int PAL_LINES    = 312;
   localparam int VBLANK_LINE    = 225;
   localparam int VBLANK_LINE_OS = 240;
   localparam int JOYPAD_LINE    = 227;
   localparam int JOYPAD_LINE_OS = 242;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      KIND_POLL     = 2'd0,
      KIND_LINE     = 2'd1,
      KIND_INSN_END = 2'd2,
      KIND_CLEAR    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_HIRQ_ENABLE  = 3'd0,
      REG_VIRQ_ENABLE  = 3'd1,
      REG_NMI_ENABLE   = 3'd2,
      REG_HTIME        = 3'd3,
      REG_VTIME        = 3'd4,
      REG_PAL_REGION   = 3'd5,
      REG_OVERSCAN     = 3'd6,
      REG_AUTO_JOYPAD  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic       hirq_enable;
      logic       virq_enable;
      logic       nmi_enable;
      logic [8:0] htime;
      logic [8:0] vtime;
      logic       pal_region;
      logic       overscan;
      logic       auto_joypad_enable;
   } cfg_type;

   // values derived from the registers, held in flops
   typedef struct packed {
      logic [POS_W-1:0]   target_hv;
      logic [FRAME_W-1:0] frame_len;
   } cfg_derived_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  clocks;
      logic [8:0]  vcounter;
      logic [10:0] hcounter;
      logic        field;
      logic        irq_mask;
      logic        int_lock;
      logic        external_irq;
      logic [3:0]  clear_mask;
   } item_type;

   typedef struct packed {
      logic irq_window_valid;
      logic irq_flag;
      logic irq_edge;
      logic vblank_valid;
      logic vblank_flag;
      logic nmi_edge;
      logic nmi_wait;
      logic irq_wait;
   } state_type;

   typedef struct packed {
      logic wake;
      logic joypad_poll_start;
   } event_type;

endpackage

// ===== rtl/core/hvirq_eval.sv =====
// next-state and result logic for one request of the interrupt unit
// depends on hvirq_pkg
module hvirq_eval (
   input  hvirq_pkg::item_type        item,
   input  hvirq_pkg::cfg_type         cfg,
   input  hvirq_pkg::cfg_derived_type drv,
   input  hvirq_pkg::state_type       state,
   output hvirq_pkg::state_type       state_next,
   output hvirq_pkg::event_type       events
);
   import hvirq_pkg::*;

   localparam logic [POS_W-1:0] LINE_W = POS_W'(LINE_CLOCKS);

   logic [POS_W-1:0] now;
   logic [POS_W-1:0] target;
   logic [POS_W-1:0] wrap;
   logic [POS_W-1:0] target_adj;
   logic [POS_W-1:0] gap;
   logic             window_hit;
   logic             window;
   logic [8:0]       vblank_line;
   logic [8:0]       joypad_line;

   always_comb begin
      if (cfg.virq_enable) begin
         now    = POS_W'(item.vcounter) * LINE_W + POS_W'(item.hcounter);
         target = drv.target_hv;
         wrap   = POS_W'(drv.frame_len) + (item.field ? LINE_W : '0);
      end else begin
         now    = POS_W'(item.hcounter);
         target = POS_W'({cfg.htime, 2'b00});
         wrap   = LINE_W;
      end
      target_adj = (now > target) ? target + wrap : target;
      gap        = target_adj - now;
      // a target still behind after one wrap never matches
      window_hit = (target_adj >= now) && (gap < POS_W'(item.clocks));
   end

   assign window      = cfg.hirq_enable ? window_hit : (item.vcounter == cfg.vtime);
   assign vblank_line = cfg.overscan ? 9'(VBLANK_LINE_OS) : 9'(VBLANK_LINE);
   assign joypad_line = cfg.overscan ? 9'(JOYPAD_LINE_OS) : 9'(JOYPAD_LINE);

   always_comb begin
      state_next = state;
      events     = '0;
      case (kind_type'(item.kind))
         KIND_POLL: begin
            if (cfg.hirq_enable || cfg.virq_enable) begin
               if (!state.irq_window_valid && window) begin
                  state_next.irq_flag = 1'b1;
               end
               state_next.irq_window_valid = window;
               if (state_next.irq_flag) begin
                  state_next.irq_edge = 1'b1;
               end
            end else begin
               state_next.irq_window_valid = 1'b0;
            end
         end
         KIND_LINE: begin
            state_next.vblank_valid = item.vcounter >= vblank_line;
            if (!state.vblank_valid && state_next.vblank_valid) begin
               state_next.vblank_flag = 1'b1;
               if (cfg.nmi_enable) begin
                  state_next.nmi_edge = 1'b1;
               end
            end else if (state.vblank_valid && !state_next.vblank_valid) begin
               state_next.vblank_flag = 1'b0;
            end
            events.joypad_poll_start = cfg.auto_joypad_enable &&
                                       (item.vcounter == joypad_line);
         end
         KIND_INSN_END: begin
            if (!item.int_lock) begin
               if (state.nmi_edge) begin
                  events.wake         = 1'b1;
                  state_next.nmi_edge = 1'b0;
                  state_next.nmi_wait = 1'b1;
               end
               if (state.irq_edge || item.external_irq) begin
                  events.wake         = 1'b1;
                  state_next.irq_edge = 1'b0;
                  state_next.irq_wait = !item.irq_mask;
               end
            end
         end
         KIND_CLEAR: begin
            if (item.clear_mask[0]) state_next.irq_flag    = 1'b0;
            if (item.clear_mask[1]) state_next.nmi_wait    = 1'b0;
            if (item.clear_mask[2]) state_next.irq_wait    = 1'b0;
            if (item.clear_mask[3]) state_next.vblank_flag = 1'b0;
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

// ===== rtl/core/hv_position_interrupt_unit.sv =====
// Raster-position interrupt unit. Each request (access poll, line start, instruction end
// or flag clear) is taken into an input register, evaluated combinationally against the
// interrupt state and the configuration, and its result lands in an output register, so
// one request is accepted per clock while results are taken, and a new request enters
// while a result waits to be taken. rsp_valid rises as a request moves from the input
// register to the output register; the single evaluation stage holds a constant multiply
// by the line length, an add and a compare. Registers sit on the APB-style port at byte
// address 4*index; write them only while idle. Depends on hvirq_pkg and hvirq_eval.
module hv_position_interrupt_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_kind,
   input  logic [7:0]                       req_clocks,
   input  logic [8:0]                       req_vcounter,
   input  logic [10:0]                      req_hcounter,
   input  logic                             req_field,
   input  logic                             req_irq_mask,
   input  logic                             req_irq_lock,
   input  logic                             req_external_irq,
   input  logic [3:0]                       req_clear_mask,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_nmi_pending,
   output logic                             rsp_irq_pending,
   output logic                             rsp_irq_line,
   output logic                             rsp_nmi_line,
   output logic                             rsp_wake,
   output logic                             rsp_joypad_poll_start,
   // configuration port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [hvirq_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [hvirq_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hvirq_pkg::CSR_DATA_W-1:0] prdata,
   output logic                             pready
);
   import hvirq_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   cfg_derived_type drv_ff, drv_in;
   state_type       state_ff, state_in;
   item_type        item_ff, item_in;
   logic            stage_valid_ff, stage_valid_in;
   logic            rsp_valid_ff, rsp_valid_in;
   state_type       result_ff, result_in;
   event_type       event_ff, event_in;
   state_type       state_next;
   event_type       events;
   logic            advance;
   logic            csr_write;
   reg_index_type   csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_HIRQ_ENABLE: cfg_in.hirq_enable        = pwdata[0];
            REG_VIRQ_ENABLE: cfg_in.virq_enable        = pwdata[0];
            REG_NMI_ENABLE:  cfg_in.nmi_enable         = pwdata[0];
            REG_HTIME:       cfg_in.htime              = pwdata[8:0];
            REG_VTIME:       cfg_in.vtime              = pwdata[8:0];
            REG_PAL_REGION:  cfg_in.pal_region         = pwdata[0];
            REG_OVERSCAN:    cfg_in.overscan           = pwdata[0];
            REG_AUTO_JOYPAD: cfg_in.auto_joypad_enable = pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_HIRQ_ENABLE: prdata = CSR_DATA_W'(cfg_ff.hirq_enable);
         REG_VIRQ_ENABLE: prdata = CSR_DATA_W'(cfg_ff.virq_enable);
         REG_NMI_ENABLE:  prdata = CSR_DATA_W'(cfg_ff.nmi_enable);
         REG_HTIME:       prdata = CSR_DATA_W'(cfg_ff.htime);
         REG_VTIME:       prdata = CSR_DATA_W'(cfg_ff.vtime);
         REG_PAL_REGION:  prdata = CSR_DATA_W'(cfg_ff.pal_region);
         REG_OVERSCAN:    prdata = CSR_DATA_W'(cfg_ff.overscan);
         REG_AUTO_JOYPAD: prdata = CSR_DATA_W'(cfg_ff.auto_joypad_enable);
         default:         prdata = '0;
      endcase
   end

   // combined h+v target and frame length only change with the registers
   always_comb begin
      drv_in.target_hv = POS_W'(cfg_ff.vtime) * POS_W'(LINE_CLOCKS) +
                         POS_W'({cfg_ff.htime, 2'b00});
      drv_in.frame_len = cfg_ff.pal_region ? FRAME_W'(PAL_LINES * LINE_CLOCKS)
                                           : FRAME_W'(NTSC_LINES * LINE_CLOCKS);
   end

   hvirq_eval u_eval (
      .item       (item_ff),
      .cfg        (cfg_ff),
      .drv        (drv_ff),
      .state      (state_ff),
      .state_next (state_next),
      .events     (events)
   );

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;

   always_comb begin
      item_in        = item_ff;
      stage_valid_in = stage_valid_ff;
      if (req_ready) begin
         stage_valid_in = req_valid;
         item_in = '{kind: req_kind, clocks: req_clocks, vcounter: req_vcounter,
                     hcounter: req_hcounter, field: req_field, irq_mask: req_irq_mask,
                     int_lock: req_irq_lock, external_irq: req_external_irq,
                     clear_mask: req_clear_mask};
      end
      state_in     = advance ? state_next : state_ff;
      result_in    = advance ? state_next : result_ff;
      event_in     = advance ? events : event_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      drv_ff    <= drv_in;
      result_ff <= result_in;
      event_ff  <= event_in;
      if (reset) begin
         cfg_ff         <= '{htime: 9'h1FF, vtime: 9'h1FF, default: '0};
         state_ff       <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cfg_ff         <= cfg_in;
         state_ff       <= state_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_nmi_pending       = result_ff.nmi_wait;
   assign rsp_irq_pending       = result_ff.irq_wait;
   assign rsp_irq_line          = result_ff.irq_flag;
   assign rsp_nmi_line          = result_ff.vblank_flag;
   assign rsp_wake              = event_ff.wake;
   assign rsp_joypad_poll_start = event_ff.joypad_poll_start;

endmodule
